// ----- hw/rtl/owned_key_value_table_top_assert.svh -----
// assertion macros for the rtl file that checks itself, okvt_ctrl
`ifndef OWNED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define OWNED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, idle while i_rst_n is low
`define OKVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OKVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/okvt_pkg.sv -----
`default_nettype none

package okvt_pkg;

    localparam int FIELD_W = 64;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_GET    = 2'd1,
        FN_SET    = 2'd2,
        FN_DELETE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_PERM      = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DECIDE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [FIELD_W-1:0] key_name;
        logic [FIELD_W-1:0] owner_tag;
        logic [FIELD_W-1:0] new_value;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] read_owner;
        logic [FIELD_W-1:0] read_value;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] name;
        logic [FIELD_W-1:0] owner;
        logic [FIELD_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // keep bytes below nbytes, stopping at the first zero byte
    function automatic logic [FIELD_W-1:0] cut_bytes(input logic [FIELD_W-1:0] v,
                                                      input int nbytes);
        logic [FIELD_W-1:0] r;
        logic               stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < FIELD_W / 8; i++) begin
            if (i >= nbytes || v[8*i +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/owned_key_value_table_top.sv -----
// channel   dir  width            contents
// s_axis    in   tdata 192, tuser 2   key_name, owner_tag, new_value / func
// m_axis    out  tdata 136            status, read_owner, read_value
//
// every item is accepted, streamed entry by entry through the single ram read
// port and name compare, then passes a tail state for the last compare and a
// decision state with its write-back
// after reset a clearing pass writes every entry, tready low
// a result sits in the output register; the decision waits while it is full
`default_nettype none

module owned_key_value_table_top
    import okvt_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int NAME_BYTES = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [191:0]  s_axis_tdata,   // key_name, owner_tag, new_value
    input  wire logic [1:0]    s_axis_tuser,   // func
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [135:0]       m_axis_tdata    // status, read_owner, read_value, zero pad
);

    t_item    in_item;
    t_result  res;
    logic     res_load;
    logic     out_free;
    logic     start;
    logic     r_out_valid;
    t_result  r_out;

    assign in_item.func      = t_func'(s_axis_tuser);
    assign in_item.key_name  = s_axis_tdata[63:0];
    assign in_item.owner_tag = s_axis_tdata[127:64];
    assign in_item.new_value = s_axis_tdata[191:128];

    assign start    = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    okvt_ctrl #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (in_item),
        .o_ready    (s_axis_tready),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.read_value, r_out.read_owner, r_out.status};

endmodule

`default_nettype wire

// ----- hw/rtl/okvt_ram.sv -----
`default_nettype none

module okvt_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/okvt_ctrl.sv -----
`default_nettype none

module okvt_ctrl
    import okvt_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int NAME_BYTES = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_item   i_item,
    output logic         o_ready,
    input  wire logic    i_out_free,
    output logic         o_res_load,
    output t_result      o_res
);

    localparam int              AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0]   LAST = AW'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;
    t_func               r_func;
    logic [FIELD_W-1:0]  r_key;
    logic [FIELD_W-1:0]  r_owner;
    logic [FIELD_W-1:0]  r_value;
    logic                r_hit;
    logic [AW-1:0]       r_hit_idx;
    logic [FIELD_W-1:0]  r_hit_owner;
    logic [FIELD_W-1:0]  r_hit_value;
    logic                r_free;
    logic [AW-1:0]       r_free_idx;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    t_entry              rd_entry;
    logic [ENTRY_W-1:0]  rd_raw;

    logic                name_eq;
    logic                owner_eq;
    t_status             dec_status;
    logic                dec_we;
    logic [AW-1:0]       dec_idx;
    t_entry              dec_entry;

    okvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (rd_raw)
    );

    assign rd_entry = t_entry'(rd_raw);

    // the one name compare unit, applied to each entry as it comes out of the ram
    assign name_eq  = rd_entry.valid && (rd_entry.name == r_key);
    assign owner_eq = (cut_bytes(r_hit_owner, FIELD_W / 8) ==
                       cut_bytes(r_owner, FIELD_W / 8));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_addr == LAST) n_state = S_IDLE;
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (r_addr == LAST) n_state = S_TAIL;
            S_TAIL:   n_state = S_DECIDE;
            S_DECIDE: if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // decision over the scan results
    always_comb begin
        dec_status       = ST_OK;
        dec_we           = 1'b0;
        dec_idx          = r_hit_idx;
        dec_entry.valid  = 1'b1;
        dec_entry.name   = r_key;
        dec_entry.owner  = r_hit_owner;
        dec_entry.value  = r_hit_value;
        o_res.read_owner = '0;
        o_res.read_value = '0;
        if (r_func == FN_ADD) begin
            if (r_hit) begin
                dec_status = ST_EXISTS;
            end else if (!r_free) begin
                dec_status = ST_FULL;
            end else begin
                dec_we          = 1'b1;
                dec_idx         = r_free_idx;
                dec_entry.owner = r_owner;
                dec_entry.value = r_value;
            end
        end else if (!r_hit) begin
            dec_status = ST_NOT_FOUND;
        end else if (r_func == FN_GET) begin
            o_res.read_owner = r_hit_owner;
            o_res.read_value = r_hit_value;
        end else if (!owner_eq) begin
            dec_status = ST_PERM;
        end else if (r_func == FN_SET) begin
            dec_we          = 1'b1;
            dec_entry.value = r_value;
        end else begin
            dec_we          = 1'b1;
            dec_entry.valid = 1'b0;
        end
        o_res.status = dec_status;
    end

    always_comb begin
        o_ready    = 1'b0;
        o_res_load = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_SCAN: begin
                ram_re = 1'b1;
            end
            S_TAIL: begin
            end
            S_DECIDE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    ram_we     = dec_we;
                    ram_waddr  = dec_idx;
                    ram_wdata  = dec_entry;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= (r_addr == LAST) ? '0 : AW'(r_addr + 1'b1);
            end
            if (r_state == S_IDLE && i_start) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_vld) begin
                if (name_eq && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!rd_entry.valid && !r_free) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    // payload side, no reset needed
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (r_state == S_IDLE && i_start) begin
            r_func  <= i_item.func;
            r_key   <= cut_bytes(i_item.key_name, NAME_BYTES);
            r_owner <= i_item.owner_tag;
            r_value <= i_item.new_value;
        end
        if (r_rd_vld && name_eq && !r_hit) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_owner <= rd_entry.owner;
            r_hit_value <= rd_entry.value;
        end
        // lowest free entry wins
        if (r_rd_vld && !rd_entry.valid && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

`include "owned_key_value_table_top_assert.svh"

    `OKVT_ASSERT_NOW(a_no_write_in_scan, r_state == S_SCAN || r_state == S_TAIL, !ram_we, "ram written during scan")
    `OKVT_ASSERT_NEXT(a_start_scans_from_zero, r_state == S_IDLE && i_start, r_state == S_SCAN && r_addr == '0, "scan did not start at entry zero")
    `OKVT_ASSERT_NOW(a_fail_reads_zero, o_res_load && o_res.status != ST_OK, o_res.read_owner == '0 && o_res.read_value == '0, "failed transaction returns data")
    `OKVT_ASSERT_NOW(a_load_only_in_decide, o_res_load, r_state == S_DECIDE && i_out_free, "result loaded outside decision")

endmodule

`default_nettype wire

// ----- tb/sv/tb_owned_key_value_table_top.sv -----
`timescale 1ns / 100ps

module tb_owned_key_value_table_top
    import okvt_pkg::*;
();

    localparam int TABLE_DEPTH  = 16;
    localparam int KEY_BYTES    = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int BLOCK_ITEMS  = 50;
    localparam int NAME_POOL    = 24;
    localparam int OWNER_POOL   = 4;
    localparam int IDLE_PCT     = 13;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 2 * (TABLE_DEPTH + 3);

    // mirror of the record store, one expected result per accepted transaction
    class kv_table_scoreboard;
        bit          live[TABLE_DEPTH];
        logic [63:0] names[TABLE_DEPTH];
        logic [63:0] owners[TABLE_DEPTH];
        logic [63:0] values[TABLE_DEPTH];
        t_result     pending_results[$];
        int          errors;
        int          checked;
        int          status_count[5];

        function logic [63:0] strip_text(logic [63:0] v, int nbytes);
            logic [63:0] r;
            bit          stop;
            r    = '0;
            stop = 1'b0;
            for (int b = 0; b < 8; b++) begin
                if (b >= nbytes || v[8*b +: 8] == 8'h00) begin
                    stop = 1'b1;
                end
                if (!stop) begin
                    r[8*b +: 8] = v[8*b +: 8];
                end
            end
            return r;
        endfunction

        function void note_item(t_item it);
            logic [63:0] lookup;
            int          hit;
            int          slot;
            t_result     outcome;
            lookup             = strip_text(it.key_name, KEY_BYTES);
            hit                = -1;
            slot               = -1;
            outcome.status     = ST_OK;
            outcome.read_owner = '0;
            outcome.read_value = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (live[i] && names[i] == lookup && hit < 0) begin
                    hit = i;
                end
                if (!live[i] && slot < 0) begin
                    slot = i;
                end
            end
            if (it.func == FN_ADD) begin
                if (hit >= 0) begin
                    outcome.status = ST_EXISTS;
                end else if (slot < 0) begin
                    outcome.status = ST_FULL;
                end else begin
                    live[slot]   = 1'b1;
                    names[slot]  = lookup;
                    owners[slot] = it.owner_tag;
                    values[slot] = it.new_value;
                end
            end else if (hit < 0) begin
                outcome.status = ST_NOT_FOUND;
            end else if (it.func == FN_GET) begin
                outcome.read_owner = owners[hit];
                outcome.read_value = values[hit];
            end else if (strip_text(owners[hit], 8) != strip_text(it.owner_tag, 8)) begin
                outcome.status = ST_PERM;
            end else if (it.func == FN_SET) begin
                values[hit] = it.new_value;
            end else begin
                live[hit] = 1'b0;
            end
            pending_results.push_back(outcome);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_count[int'(want.status)]++;
            if (got.status !== want.status) begin
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
            if (got.read_owner !== want.read_owner) begin
                report($sformatf("owner %h, expected %h", got.read_owner, want.read_owner));
            end
            if (got.read_value !== want.read_value) begin
                report($sformatf("value %h, expected %h", got.read_value, want.read_value));
            end
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata  = '0;   // key_name, owner_tag, new_value
    logic [1:0]   s_axis_tuser  = '0;   // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;         // status, read_owner, read_value, zero pad

    kv_table_scoreboard table_model = new();
    t_result            got_result;
    bit                 calm = 1'b0;
    int                 sent_items = 0;
    int                 stall_cycles = 0;
    logic [63:0]        name_pool[NAME_POOL];
    int                 name_len[NAME_POOL];
    logic [63:0]        owner_pool[OWNER_POOL];
    int                 owner_len[OWNER_POOL];

    owned_key_value_table_top #(
        .ENTRIES    (TABLE_DEPTH),
        .NAME_BYTES (KEY_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] text_of(int len);
        logic [63:0] r;
        r = '0;
        for (int b = 0; b < len; b++) begin
            r[8*b +: 8] = 8'($urandom_range(1, 255));
        end
        return r;
    endfunction

    // random bytes beyond the terminating zero, which must not matter
    function automatic logic [63:0] with_junk(logic [63:0] base, int len);
        logic [63:0] r;
        r = base;
        for (int b = len + 1; b < 8; b++) begin
            if ($urandom_range(0, 1) == 1) begin
                r[8*b +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return r;
    endfunction

    function automatic t_item item_of(t_func f, logic [63:0] name, logic [63:0] owner,
                                      logic [63:0] value);
        t_item it;
        it.func      = f;
        it.key_name  = name;
        it.owner_tag = owner;
        it.new_value = value;
        return it;
    endfunction

    function automatic t_item random_item(bit fill_phase);
        t_item it;
        int    pick;
        int    idx;
        if ($urandom_range(0, 99) < 5) begin
            return item_of(t_func'($urandom_range(0, 3)), rand64(), rand64(), rand64());
        end
        pick = $urandom_range(0, 99);
        if (fill_phase) begin
            it.func = pick < 55 ? FN_ADD : pick < 75 ? FN_GET : pick < 90 ? FN_SET : FN_DELETE;
        end else begin
            it.func = pick < 20 ? FN_ADD : pick < 45 ? FN_GET : pick < 65 ? FN_SET : FN_DELETE;
        end
        if ($urandom_range(0, 99) < 92) begin
            idx         = $urandom_range(0, NAME_POOL - 1);
            it.key_name = with_junk(name_pool[idx], name_len[idx]);
        end else begin
            it.key_name = rand64();
        end
        if ($urandom_range(0, 99) < 85) begin
            idx          = $urandom_range(0, OWNER_POOL - 1);
            it.owner_tag = with_junk(owner_pool[idx], owner_len[idx]);
        end else begin
            it.owner_tag = rand64();
        end
        it.new_value = rand64();
        return it;
    endfunction

    task automatic send_item(t_item it);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.new_value, it.owner_tag, it.key_name};
        s_axis_tuser  <= it.func;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        table_model.note_item(it);
        sent_items++;
    endtask

    // result side: check on each accepted transaction, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result.status     = t_status'(m_axis_tdata[2:0]);
            got_result.read_owner = m_axis_tdata[66:3];
            got_result.read_value = m_axis_tdata[130:67];
            table_model.check_result(got_result);
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, table_model.pending());
            $display("tb_owned_key_value_table_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SHORT_NAME = 64'h0000_0000_0000_4B4F;
    localparam logic [63:0] SHORT_OWNER = 64'hA5A5_0000_0000_6162;

    initial begin
        for (int i = 0; i < NAME_POOL; i++) begin
            name_len[i]  = $urandom_range(0, 8);
            name_pool[i] = text_of(name_len[i]);
        end
        for (int i = 0; i < OWNER_POOL; i++) begin
            owner_len[i]  = $urandom_range(0, 8);
            owner_pool[i] = text_of(owner_len[i]);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, then a full eight-byte name at the extremes
        send_item(item_of(FN_GET, ALL_ONES, 64'h0, 64'h0));
        send_item(item_of(FN_SET, ALL_ONES, ALL_ONES, ALL_ONES));
        send_item(item_of(FN_DELETE, ALL_ONES, ALL_ONES, 64'h0));
        send_item(item_of(FN_ADD, ALL_ONES, ALL_ONES, ALL_ONES));
        send_item(item_of(FN_ADD, ALL_ONES, 64'h0, 64'h0));
        send_item(item_of(FN_GET, ALL_ONES, 64'h0, 64'h0));
        // empty name, and a lookup whose first byte is already zero
        send_item(item_of(FN_ADD, 64'h0, 64'h0, 64'h0));
        send_item(item_of(FN_GET, 64'hDEAD_BEEF_0000_0000, ALL_ONES, ALL_ONES));
        // bytes past the terminator are ignored, stored owner comes back untouched
        send_item(item_of(FN_ADD, 64'h5A00_1234_0000_4B4F, SHORT_OWNER, 64'h123));
        send_item(item_of(FN_GET, SHORT_NAME, 64'h0, 64'h0));
        send_item(item_of(FN_SET, 64'h0077_0000_0000_4B4F, 64'h6163, 64'h5555));
        send_item(item_of(FN_SET, SHORT_NAME, 64'hFFFF_0000_0000_6162, 64'hCAFE));
        send_item(item_of(FN_GET, SHORT_NAME, 64'h0, 64'h0));
        send_item(item_of(FN_DELETE, SHORT_NAME, 64'h62, 64'h0));
        send_item(item_of(FN_DELETE, SHORT_NAME, 64'h6162, 64'h0));
        send_item(item_of(FN_GET, SHORT_NAME, 64'h0, 64'h0));
        send_item(item_of(FN_DELETE, ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0));
        send_item(item_of(FN_SET, ALL_ONES, ALL_ONES, 64'h0));
        send_item(item_of(FN_DELETE, 64'h0, 64'h0, 64'h0));
        send_item(item_of(FN_ADD, SHORT_NAME, 64'h31, 64'h8000_0000_0000_0001));

        // alternate fill-heavy and drain-heavy blocks so the store runs full and empty
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n / BLOCK_ITEMS) == 3;
            send_item(random_item((n / BLOCK_ITEMS) % 2 == 0));
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (table_model.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d transactions in, %0d results checked, %0d mismatches",
                 sent_items, table_model.checked, table_model.errors);
        $display("statuses: ok %0d, exists %0d, absent %0d, wrong owner %0d, full %0d",
                 table_model.status_count[0], table_model.status_count[1],
                 table_model.status_count[2], table_model.status_count[3],
                 table_model.status_count[4]);
        if (table_model.errors == 0) begin
            $display("tb_owned_key_value_table_top OK");
        end else begin
            $display("tb_owned_key_value_table_top NOT OK");
        end
        $finish;
    end

endmodule
